@@ rtl/bafg_pkg.sv @@
// bafg_pkg: shared types and constants for the bus address filter with group table.
// Used by bafg_cell and bus_address_filter_with_group_table; no dependencies.
package bafg_pkg;

    localparam int GROUP_ENTRIES_DEF = 8;
    localparam int ADDRESS_WIDTH_DEF = 8;

    localparam int IN_ADDR_W = 8;
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd0;
    localparam logic [OP_W-1:0] OP_JOIN     = 2'd1;
    localparam logic [OP_W-1:0] OP_LEAVE    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDRESS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULTICAST_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BROADCAST_ADDRESS = 2'd2;

    localparam int MC_MASK_RST  = 128;
    localparam int BCAST_RST    = 255;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [IN_ADDR_W-1:0] address;
    } t_in_beat;

    typedef struct packed {
        logic status_ok;
        logic is_local;
        logic is_broadcast;
        logic is_multicast;
        logic is_unicast;
        logic is_group_member;
    } t_out_beat;

    // Control token that walks down the cell chain with the address
    typedef struct packed {
        logic            vld;
        logic [OP_W-1:0] op;
        logic            is_local;
        logic            is_bc;
        logic            is_mc;
        logic            done;
        logic            member;
    } t_tok;

endpackage

@@ rtl/bus_address_filter_with_group_table.sv @@
// bus_address_filter_with_group_table: top level, config registers, classify, result buffer.
// Depends on bafg_pkg and bafg_cell.
//
// Classifies a bus address against the local, broadcast and multicast settings and
// keeps a table of joined multicast groups (zero marks a free slot, cleared at reset).
// Join stores a multicast address in the first free slot, leave clears the first match.
// The table is a row of GROUP_ENTRIES cells; the item's token steps through one cell per
// cycle. Only one item is in the chain at a time: a new beat is not taken until the token
// of the last one has left the last cell. One finished result can wait on the output
// while the next beat is worked on. Configuration writes are always ready and must only
// be issued while the block is idle.
module bus_address_filter_with_group_table #(
    parameter int GROUP_ENTRIES = bafg_pkg::GROUP_ENTRIES_DEF,
    parameter int ADDRESS_WIDTH = bafg_pkg::ADDRESS_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  bafg_pkg::t_in_beat               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output bafg_pkg::t_out_beat              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bafg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ADDRESS_WIDTH-1:0]         i_cfg_data
);

    localparam logic [ADDRESS_WIDTH-1:0] MC_RST = ADDRESS_WIDTH'(bafg_pkg::MC_MASK_RST);
    localparam logic [ADDRESS_WIDTH-1:0] BC_RST = ADDRESS_WIDTH'(bafg_pkg::BCAST_RST);

    logic [ADDRESS_WIDTH-1:0] r_local;
    logic [ADDRESS_WIDTH-1:0] r_mc_mask;
    logic [ADDRESS_WIDTH-1:0] r_bcast;

    logic                     r_busy;
    logic                     r_out_vld;
    bafg_pkg::t_out_beat      r_out;
    logic                     r_skid_vld;
    bafg_pkg::t_out_beat      r_skid;

    logic                     w_accept;
    logic                     w_cfg_we;
    logic                     w_take;
    logic [ADDRESS_WIDTH+bafg_pkg::IN_ADDR_W-1:0] w_addr_ext;
    logic [ADDRESS_WIDTH-1:0] w_addr_in;
    logic                     w_bc;
    logic                     w_mc;
    bafg_pkg::t_out_beat      w_fin;
    logic                     w_fin_vld;

    bafg_pkg::t_tok           w_tok  [0:GROUP_ENTRIES];
    logic [ADDRESS_WIDTH-1:0] w_addr [0:GROUP_ENTRIES];

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid;
    assign o_in_stall  = r_busy | r_skid_vld;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign w_take      = r_out_vld & ~i_out_stall;

    // Bits above ADDRESS_WIDTH are dropped, missing ones are zero
    assign w_addr_ext = {{ADDRESS_WIDTH{1'b0}}, i_in_data.address};
    assign w_addr_in  = w_addr_ext[ADDRESS_WIDTH-1:0];
    assign w_bc       = (w_addr_in == r_bcast);
    assign w_mc       = ((w_addr_in & r_mc_mask) != '0) & ~w_bc;

    always_comb begin
        w_tok[0]          = '0;
        w_tok[0].vld      = w_accept;
        w_tok[0].op       = i_in_data.operation;
        w_tok[0].is_local = (w_addr_in == r_local);
        w_tok[0].is_bc    = w_bc;
        w_tok[0].is_mc    = w_mc;
    end
    assign w_addr[0] = w_addr_in;

    for (genvar g = 0; g < GROUP_ENTRIES; g++) begin : g_cell
        bafg_cell #(
            .ADDRESS_WIDTH(ADDRESS_WIDTH)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_tok[g]),
            .i_addr (w_addr[g]),
            .o_tok  (w_tok[g+1]),
            .o_addr (w_addr[g+1])
        );
    end

    assign w_fin_vld = w_tok[GROUP_ENTRIES].vld;

    always_comb begin
        w_fin.status_ok       = (w_tok[GROUP_ENTRIES].op == bafg_pkg::OP_CLASSIFY) |
                                (((w_tok[GROUP_ENTRIES].op == bafg_pkg::OP_JOIN) |
                                  (w_tok[GROUP_ENTRIES].op == bafg_pkg::OP_LEAVE)) &
                                 w_tok[GROUP_ENTRIES].done);
        w_fin.is_local        = w_tok[GROUP_ENTRIES].is_local;
        w_fin.is_broadcast    = w_tok[GROUP_ENTRIES].is_bc;
        w_fin.is_multicast    = w_tok[GROUP_ENTRIES].is_mc;
        w_fin.is_unicast      = ~w_tok[GROUP_ENTRIES].is_bc & ~w_tok[GROUP_ENTRIES].is_mc;
        w_fin.is_group_member = w_tok[GROUP_ENTRIES].member;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local   <= '0;
            r_mc_mask <= MC_RST;
            r_bcast   <= BC_RST;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                bafg_pkg::REG_LOCAL_ADDRESS:     r_local   <= i_cfg_data;
                bafg_pkg::REG_MULTICAST_MASK:    r_mc_mask <= i_cfg_data;
                bafg_pkg::REG_BROADCAST_ADDRESS: r_bcast   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // One item in the chain at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_fin_vld) begin
            r_busy <= 1'b0;
        end
    end

    // Output register plus one skid entry for a result that finishes while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_take || !r_out_vld) begin
            r_out_vld  <= r_skid_vld | w_fin_vld;
            r_skid_vld <= r_skid_vld & w_fin_vld;
        end else if (w_fin_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take || !r_out_vld) begin
            if (r_skid_vld) begin
                r_out  <= r_skid;
                r_skid <= w_fin;
            end else begin
                r_out  <= w_fin;
            end
        end else if (w_fin_vld) begin
            r_skid <= w_fin;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

@@ rtl/bafg_cell.sv @@
// bafg_cell: one group table slot; updates its entry as the token passes and forwards it.
// Depends on bafg_pkg (t_tok, operation codes).
module bafg_cell #(
    parameter int ADDRESS_WIDTH = bafg_pkg::ADDRESS_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bafg_pkg::t_tok           i_tok,
    input  logic [ADDRESS_WIDTH-1:0] i_addr,
    output bafg_pkg::t_tok           o_tok,
    output logic [ADDRESS_WIDTH-1:0] o_addr
);

    logic [ADDRESS_WIDTH-1:0] r_entry;
    logic [ADDRESS_WIDTH-1:0] n_entry;
    logic [ADDRESS_WIDTH-1:0] r_addr;
    bafg_pkg::t_tok           r_tok;
    bafg_pkg::t_tok           n_tok;
    logic                     w_addr_nz;
    logic                     w_hit;
    logic                     w_free;

    assign w_addr_nz = (i_addr != '0);
    assign w_hit     = (r_entry == i_addr);
    assign w_free    = (r_entry == '0);

    always_comb begin
        n_tok   = i_tok;
        n_entry = r_entry;
        if (i_tok.vld) begin
            // membership looks at the entry before any update in this slot
            n_tok.member = i_tok.member | (w_hit & w_addr_nz);
            if (!i_tok.done) begin
                if (i_tok.op == bafg_pkg::OP_JOIN && i_tok.is_mc && w_free) begin
                    n_entry    = i_addr;
                    n_tok.done = 1'b1;
                end else if (i_tok.op == bafg_pkg::OP_LEAVE && w_addr_nz && w_hit) begin
                    n_entry    = '0;
                    n_tok.done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= '0;
            r_entry <= '0;
        end else begin
            r_tok   <= n_tok;
            r_entry <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= i_addr;
    end

    assign o_tok  = r_tok;
    assign o_addr = r_addr;

endmodule

@@ verif/tb_top.sv @@
// tb_top: self-checking bench for bus_address_filter_with_group_table.
// Directed table then random phases under several config and idling mixes.
// Depends on bafg_pkg and the filter RTL.
module tb_top;

    localparam int GROUP_N = bafg_pkg::GROUP_ENTRIES_DEF;
    localparam logic [bafg_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int MODE_NONE = 0;
    localparam int MODE_SEND = 1;
    localparam int MODE_RECV = 2;
    localparam int MODE_BOTH = 3;
    localparam int PHASES = 8;
    localparam int BEATS_PER_PHASE = 135;

    typedef struct {
        bafg_pkg::t_in_beat  beat;
        bit                  fixed;
        bafg_pkg::t_out_beat res;
    } t_plan_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    bafg_pkg::t_in_beat  i_in_data = '0;
    logic      i_out_stall = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic [bafg_pkg::CFG_IDX_W-1:0] i_cfg_index = bafg_pkg::REG_LOCAL_ADDRESS;
    logic [bafg_pkg::ADDRESS_WIDTH_DEF-1:0] i_cfg_data = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    bafg_pkg::t_out_beat o_out_data;
    logic      o_cfg_ready;

    // shadow of the filter's settings and group table
    logic [7:0] loc_reg = 8'd0;
    logic [7:0] mask_reg = 8'(bafg_pkg::MC_MASK_RST);
    logic [7:0] bcast_reg = 8'(bafg_pkg::BCAST_RST);
    logic [7:0] grp_tbl [GROUP_N];

    bafg_pkg::t_out_beat pending_flags [$];
    t_plan_row plan [$];
    bafg_pkg::t_out_beat seen_want;
    int        idle_mode = MODE_NONE;
    int        mismatches = 0;

    bus_address_filter_with_group_table uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("** bus_address_filter_with_group_table: FAILED **");
        $finish;
    end

    // flags for one address, then the table update its operation asks for
    function automatic bafg_pkg::t_out_beat classify_and_update(bafg_pkg::t_in_beat beat);
        bafg_pkg::t_out_beat r;
        logic [7:0] a;
        int         hit;
        int         free;
        a = beat.address;
        hit = GROUP_N;
        free = GROUP_N;
        for (int n = GROUP_N - 1; n >= 0; n--) begin
            if (grp_tbl[n] == a) hit = n;
            if (grp_tbl[n] == 8'd0) free = n;
        end
        r.is_local = (a == loc_reg);
        r.is_broadcast = (a == bcast_reg);
        r.is_multicast = ((a & mask_reg) != 8'd0) && !r.is_broadcast;
        r.is_unicast = !r.is_broadcast && !r.is_multicast;
        r.is_group_member = (a != 8'd0) && (hit < GROUP_N);
        r.status_ok = 1'b0;
        case (beat.operation)
            bafg_pkg::OP_CLASSIFY: r.status_ok = 1'b1;
            bafg_pkg::OP_JOIN: begin
                if (r.is_multicast && free < GROUP_N) begin
                    grp_tbl[free] = a;
                    r.status_ok = 1'b1;
                end
            end
            bafg_pkg::OP_LEAVE: begin
                if (r.is_group_member) begin
                    grp_tbl[hit] = 8'd0;
                    r.status_ok = 1'b1;
                end
            end
            default: r.status_ok = 1'b0;
        endcase
        return r;
    endfunction

    function automatic void plan_item(logic [bafg_pkg::OP_W-1:0] op, logic [7:0] addr,
                                      bit fixed, bafg_pkg::t_out_beat res);
        t_plan_row r;
        r.beat.operation = op;
        r.beat.address = addr;
        r.fixed = fixed;
        r.res = res;
        plan.push_back(r);
    endfunction

    // biased toward table contents and a small multicast pool so joins and leaves hit
    function automatic bafg_pkg::t_in_beat random_beat();
        bafg_pkg::t_in_beat b;
        int       r;
        int       pick;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            b.address = grp_tbl[$urandom_range(0, GROUP_N - 1)];
        end else if (r < 40) begin
            pick = $urandom_range(0, 2);
            b.address = (pick == 0) ? loc_reg : (pick == 1) ? bcast_reg : 8'd0;
        end else if (r < 70) begin
            b.address = (8'h80 >> $urandom_range(0, 7)) | 8'($urandom_range(0, 3));
        end else begin
            b.address = 8'($urandom);
        end
        r = $urandom_range(0, 99);
        if (r < 35) b.operation = bafg_pkg::OP_JOIN;
        else if (r < 65) b.operation = bafg_pkg::OP_LEAVE;
        else if (r < 93) b.operation = bafg_pkg::OP_CLASSIFY;
        else b.operation = OP_UNUSED;
        return b;
    endfunction

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input bafg_pkg::t_in_beat beat, input bit fixed,
                             input bafg_pkg::t_out_beat fixed_res);
        bafg_pkg::t_out_beat want;
        int        gap_pct;
        gap_pct = (idle_mode == MODE_SEND) ? 51 : (idle_mode == MODE_BOTH) ? 24 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = classify_and_update(beat);
        if (fixed) want = fixed_res;
        pending_flags.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic program_filter(input logic [7:0] loc, input logic [7:0] msk,
                                  input logic [7:0] bc);
        logic [bafg_pkg::CFG_IDX_W-1:0] idx [3];
        logic [7:0]           val [3];
        idx = '{bafg_pkg::REG_LOCAL_ADDRESS, bafg_pkg::REG_MULTICAST_MASK,
                bafg_pkg::REG_BROADCAST_ADDRESS};
        val = '{loc, msk, bc};
        i_cfg_valid <= 1'b1;
        for (int n = 0; n < 3; n++) begin
            i_cfg_index <= idx[n];
            i_cfg_data <= val[n];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (idx[n])
                bafg_pkg::REG_LOCAL_ADDRESS:     loc_reg = val[n];
                bafg_pkg::REG_MULTICAST_MASK:    mask_reg = val[n];
                bafg_pkg::REG_BROADCAST_ADDRESS: bcast_reg = val[n];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) <
                        ((idle_mode == MODE_RECV) ? 51 : (idle_mode == MODE_BOTH) ? 24 : 0));
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_flags.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result beat %p", o_out_data);
                mismatches++;
            end else begin
                seen_want = pending_flags.pop_front();
                if (seen_want !== o_out_data) begin
                    if (mismatches < 10)
                        $display("result mismatch: expected %p got %p", seen_want, o_out_data);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        logic [7:0] loc_set [PHASES];
        logic [7:0] mask_set [PHASES];
        logic [7:0] bc_set [PHASES];
        for (int n = 0; n < GROUP_N; n++) grp_tbl[n] = 8'd0;
        loc_set  = '{8'h12, 8'hFF, 8'h00, 8'($urandom), 8'h55, 8'($urandom), 8'($urandom), 8'h80};
        mask_set = '{8'h80, 8'hFF, 8'h00, 8'hF0, 8'h01, 8'($urandom), 8'h0C, 8'h7F};
        bc_set   = '{8'hFF, 8'h00, 8'hFF, 8'($urandom), 8'hAA, 8'($urandom), 8'h81, 8'hFF};

        // reset settings: local 0, mask 0x80, broadcast 0xFF
        // result bits: ok, local, broadcast, multicast, unicast, member
        plan_item(bafg_pkg::OP_CLASSIFY, 8'h00, 1, 6'b110010);
        plan_item(bafg_pkg::OP_CLASSIFY, 8'hFF, 1, 6'b101000);
        plan_item(bafg_pkg::OP_CLASSIFY, 8'h80, 1, 6'b100100);
        plan_item(bafg_pkg::OP_JOIN,     8'h7F, 1, 6'b000010);  // not multicast
        plan_item(bafg_pkg::OP_JOIN,     8'hFF, 1, 6'b001000);  // broadcast is never multicast
        plan_item(bafg_pkg::OP_LEAVE,    8'h00, 1, 6'b010010);  // zero is never a member
        plan_item(bafg_pkg::OP_LEAVE,    8'h81, 1, 6'b000100);  // not in table
        plan_item(bafg_pkg::OP_JOIN,     8'h81, 1, 6'b100100);
        plan_item(bafg_pkg::OP_JOIN,     8'h81, 1, 6'b100101);  // duplicate takes another slot
        plan_item(bafg_pkg::OP_CLASSIFY, 8'h81, 1, 6'b100101);
        for (int k = 2; k < 8; k++) plan_item(bafg_pkg::OP_JOIN, 8'h80 | 8'(k), 0, '0);
        plan_item(bafg_pkg::OP_JOIN,     8'h88, 1, 6'b000100);  // table full
        plan_item(bafg_pkg::OP_LEAVE,    8'h81, 1, 6'b100101);
        plan_item(bafg_pkg::OP_CLASSIFY, 8'h81, 1, 6'b100101);  // second copy still there
        plan_item(bafg_pkg::OP_LEAVE,    8'h81, 1, 6'b100101);
        plan_item(bafg_pkg::OP_CLASSIFY, 8'h81, 1, 6'b100100);
        plan_item(OP_UNUSED,             8'hC3, 1, 6'b000100);
        plan_item(OP_UNUSED,             8'h00, 1, 6'b010010);
        plan_item(bafg_pkg::OP_JOIN,     8'h81, 0, '0);
        plan_item(bafg_pkg::OP_CLASSIFY, 8'h85, 0, '0);

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[n]) send_beat(plan[n].beat, plan[n].fixed, plan[n].res);
        i_in_valid <= 1'b0;
        while (pending_flags.size() != 0) @(negedge i_clk);

        for (int ph = 0; ph < PHASES; ph++) begin
            idle_mode = MODE_NONE;
            program_filter(loc_set[ph], mask_set[ph], bc_set[ph]);
            idle_mode = ph % 4;
            repeat (BEATS_PER_PHASE) send_beat(random_beat(), 0, '0);
            i_in_valid <= 1'b0;
            // hold off the sender until the block has drained
            while (pending_flags.size() != 0) @(negedge i_clk);
        end

        idle_mode = MODE_NONE;
        repeat (20) @(negedge i_clk);
        if (mismatches == 0 && pending_flags.size() == 0) begin
            $display("** bus_address_filter_with_group_table: PASSED **");
        end else begin
            $display("** bus_address_filter_with_group_table: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bafg_pkg.sv
rtl/bafg_cell.sv
rtl/bus_address_filter_with_group_table.sv
verif/tb_top.sv
